// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define I128DR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i128dr assertion failed");

// condition must never be seen outside reset
`define I128DR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("i128dr forbidden condition seen");

`else

`define I128DR_ASSERT(lbl, clk, rst_n, prop)
`define I128DR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/i128dr_pkg.sv -----
package i128dr_pkg;

    localparam int FIELD_W            = 64;
    localparam int WIDE_W             = 2 * FIELD_W;
    localparam int DEF_OPERAND_WIDTH  = 128;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] dividend_hi;
        logic [FIELD_W-1:0] dividend_lo;
        logic [FIELD_W-1:0] divisor_hi;
        logic [FIELD_W-1:0] divisor_lo;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient_hi;
        logic [FIELD_W-1:0] quotient_lo;
        logic [FIELD_W-1:0] remainder_hi;
        logic [FIELD_W-1:0] remainder_lo;
        logic               divide_by_zero;
    } t_out_word;

    // control that travels along the pipeline with each word
    typedef struct packed {
        logic valid;
        logic qneg;
        logic rneg;
        logic dz;
    } t_ctrl;

endpackage

// ----- rtl/int128_divide_remainder.sv -----
// path: an accepted word passes the front, step and output registers in order
// throughput: one word per cycle unless stalled, one restoring step per stage
// a two-entry output register and skid slot keep intake going until the skid fills
// reset: synchronous active low, clears control and valid bits, not data registers
module int128_divide_remainder #(
    parameter int OPERAND_WIDTH = i128dr_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i128dr_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i128dr_pkg::t_out_word o_out_word
);

    localparam int W = OPERAND_WIDTH;

    logic              en;
    i128dr_pkg::t_ctrl s_ctrl [0:W];
    logic [W-1:0]      s_rem  [0:W];
    logic [W-1:0]      s_nq   [0:W];
    logic [W-1:0]      s_dvs  [0:W];

    i128dr_front #(
        .OPERAND_WIDTH (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_ctrl  (s_ctrl[0]),
        .o_rem   (s_rem[0]),
        .o_nq    (s_nq[0]),
        .o_dvs   (s_dvs[0])
    );

    for (genvar g = 0; g < W; g++) begin : g_step
        i128dr_step #(
            .OPERAND_WIDTH (W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (s_ctrl[g]),
            .i_rem   (s_rem[g]),
            .i_nq    (s_nq[g]),
            .i_dvs   (s_dvs[g]),
            .o_ctrl  (s_ctrl[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_nq    (s_nq[g+1]),
            .o_dvs   (s_dvs[g+1])
        );
    end

    i128dr_back #(
        .OPERAND_WIDTH (W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (s_ctrl[W]),
        .i_quo       (s_nq[W]),
        .i_rem       (s_rem[W]),
        .i_out_stall (i_out_stall),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = ~en;

endmodule

// ----- rtl/i128dr_front.sv -----
module i128dr_front #(
    parameter int OPERAND_WIDTH = i128dr_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  i128dr_pkg::t_in_word     i_word,
    output i128dr_pkg::t_ctrl        o_ctrl,
    output logic [OPERAND_WIDTH-1:0] o_rem,
    output logic [OPERAND_WIDTH-1:0] o_nq,
    output logic [OPERAND_WIDTH-1:0] o_dvs
);

    localparam int W = OPERAND_WIDTH;

    logic [i128dr_pkg::WIDE_W-1:0] n_all;
    logic [i128dr_pkg::WIDE_W-1:0] d_all;
    logic [W-1:0]                  n_w;
    logic [W-1:0]                  d_w;
    logic                          nneg;
    logic                          dneg;
    i128dr_pkg::t_ctrl             n_ctrl;
    logic [W-1:0]                  n_nq;
    logic [W-1:0]                  n_dvs;

    i128dr_pkg::t_ctrl             r_ctrl;
    logic [W-1:0]                  r_nq;
    logic [W-1:0]                  r_dvs;

    always_comb begin
        n_all = {i_word.dividend_hi, i_word.dividend_lo};
        d_all = {i_word.divisor_hi, i_word.divisor_lo};
        n_w   = n_all[W-1:0];
        d_w   = d_all[W-1:0];
        nneg  = i_word.kind & n_w[W-1];
        dneg  = i_word.kind & d_w[W-1];
        n_nq  = nneg ? ('0 - n_w) : n_w;
        n_dvs = dneg ? ('0 - d_w) : d_w;
        n_ctrl.valid = i_valid;
        n_ctrl.qneg  = nneg ^ dneg;
        n_ctrl.rneg  = nneg;
        n_ctrl.dz    = (d_w == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq  <= n_nq;
            r_dvs <= n_dvs;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = '0;
    assign o_nq   = r_nq;
    assign o_dvs  = r_dvs;

endmodule

// ----- rtl/i128dr_step.sv -----
module i128dr_step #(
    parameter int OPERAND_WIDTH = i128dr_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  i128dr_pkg::t_ctrl        i_ctrl,
    input  logic [OPERAND_WIDTH-1:0] i_rem,
    input  logic [OPERAND_WIDTH-1:0] i_nq,
    input  logic [OPERAND_WIDTH-1:0] i_dvs,
    output i128dr_pkg::t_ctrl        o_ctrl,
    output logic [OPERAND_WIDTH-1:0] o_rem,
    output logic [OPERAND_WIDTH-1:0] o_nq,
    output logic [OPERAND_WIDTH-1:0] o_dvs
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_nq;

    i128dr_pkg::t_ctrl r_ctrl;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_nq;
    logic [W-1:0]      r_dvs;

    // dividend bits leave at the top of nq while quotient bits enter below
    always_comb begin
        rem_sh = {i_rem[W-2:0], i_nq[W-1]};
        diff   = {1'b0, rem_sh} - {1'b0, i_dvs};
        ge     = ~diff[W];
        n_rem  = ge ? diff[W-1:0] : rem_sh;
        n_nq   = {i_nq[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_dvs <= i_dvs;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_dvs  = r_dvs;

endmodule

// ----- rtl/i128dr_back.sv -----
`include "assert_macros.svh"

module i128dr_back #(
    parameter int OPERAND_WIDTH = i128dr_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  i128dr_pkg::t_ctrl        i_ctrl,
    input  logic [OPERAND_WIDTH-1:0] i_quo,
    input  logic [OPERAND_WIDTH-1:0] i_rem,
    input  logic                     i_out_stall,
    output logic                     o_en,
    output logic                     o_out_valid,
    output i128dr_pkg::t_out_word    o_out_word
);

    localparam int W  = OPERAND_WIDTH;
    localparam int WW = i128dr_pkg::WIDE_W;
    localparam int FW = i128dr_pkg::FIELD_W;

    logic [W-1:0]          q_fix;
    logic [W-1:0]          r_fix;
    logic [WW-1:0]         q_ext;
    logic [WW-1:0]         r_ext;
    i128dr_pkg::t_out_word pipe_word;
    logic                  take;
    logic                  en;
    logic                  n_out_valid;
    logic                  n_skid_valid;

    logic                  r_out_valid;
    logic                  r_skid_valid;
    i128dr_pkg::t_out_word r_out_word;
    i128dr_pkg::t_out_word r_skid_word;

    always_comb begin
        q_fix = i_ctrl.qneg ? ('0 - i_quo) : i_quo;
        r_fix = i_ctrl.rneg ? ('0 - i_rem) : i_rem;
        q_ext = '0;
        r_ext = '0;
        if (!i_ctrl.dz) begin
            q_ext[W-1:0] = q_fix;
            r_ext[W-1:0] = r_fix;
        end
        pipe_word.quotient_hi    = q_ext[WW-1:FW];
        pipe_word.quotient_lo    = q_ext[FW-1:0];
        pipe_word.remainder_hi   = r_ext[WW-1:FW];
        pipe_word.remainder_lo   = r_ext[FW-1:0];
        pipe_word.divide_by_zero = i_ctrl.dz;
    end

    // skid slot catches the word leaving the pipeline while the output waits
    always_comb begin
        take         = ~r_out_valid | ~i_out_stall;
        en           = ~r_skid_valid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = i_ctrl.valid;
            end
        end else if (i_ctrl.valid && en) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_word <= r_skid_valid ? r_skid_word : pipe_word;
        end else if (i_ctrl.valid && en) begin
            r_skid_word <= pipe_word;
        end
    end

    assign o_en        = en;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `I128DR_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    `I128DR_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
    `I128DR_ASSERT(a_dz_zero, i_clk, i_rst_n, (r_out_valid && r_out_word.divide_by_zero) |-> (r_out_word.quotient_hi == '0 && r_out_word.quotient_lo == '0 && r_out_word.remainder_hi == '0 && r_out_word.remainder_lo == '0))

endmodule
